/* hdl/crs_pkg.sv */
// crs_pkg: shared types and constants of the clip rectangle stack.
// Used by crs_isect and clip_rect_stack; depends on nothing.
`default_nettype none

package crs_pkg;

    localparam int STACK_DEPTH   = 32;
    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 272;

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = 6;
    localparam int POS_W   = 15;
    localparam int SIZE_W  = 9;
    localparam int IN_W    = 16;
    localparam int CALC_W  = 18;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } rect_t;

    localparam rect_t RESET_RECT = '{
        x: '0,
        y: '0,
        w: SIZE_W'(SCREEN_WIDTH),
        h: SIZE_W'(SCREEN_HEIGHT)
    };

    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_RESET = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

endpackage

`default_nettype wire

/* hdl/crs_isect.sv */
// crs_isect: intersection of the current clip with a pushed rectangle.
// Depends on crs_pkg (rect_t and widths).
`default_nettype none

module crs_isect
    import crs_pkg::*;
(
    input  rect_t                   cur,
    input  logic signed [IN_W-1:0]  rect_x,
    input  logic signed [IN_W-1:0]  rect_y,
    input  logic signed [IN_W-1:0]  rect_w,
    input  logic signed [IN_W-1:0]  rect_h,
    output rect_t                   nxt
);

    logic signed [CALC_W-1:0] px, py, pw, ph;
    logic signed [CALC_W-1:0] cx, cy, cx2, cy2;
    logic signed [CALC_W-1:0] px2, py2;
    logic signed [CALC_W-1:0] nx, ny, ex, ey;
    logic signed [CALC_W-1:0] dw, dh;

    always_comb
    begin
        px  = CALC_W'(rect_x);
        py  = CALC_W'(rect_y);
        pw  = CALC_W'(rect_w);
        ph  = CALC_W'(rect_h);
        cx  = signed'({{(CALC_W-POS_W){1'b0}}, cur.x});
        cy  = signed'({{(CALC_W-POS_W){1'b0}}, cur.y});
        cx2 = cx + signed'({{(CALC_W-SIZE_W){1'b0}}, cur.w});
        cy2 = cy + signed'({{(CALC_W-SIZE_W){1'b0}}, cur.h});
        px2 = px + pw;
        py2 = py + ph;

        // origin takes the larger corner, far edge the smaller one
        nx = (px > cx) ? px : cx;
        ny = (py > cy) ? py : cy;
        ex = (px2 < cx2) ? px2 : cx2;
        ey = (py2 < cy2) ? py2 : cy2;
        dw = ex - nx;
        dh = ey - ny;

        nxt.x = nx[POS_W-1:0];
        nxt.y = ny[POS_W-1:0];
        nxt.w = (dw > 0) ? dw[SIZE_W-1:0] : '0;
        nxt.h = (dh > 0) ? dh[SIZE_W-1:0] : '0;
    end

endmodule

`default_nettype wire

/* hdl/clip_rect_stack.sv */
// clip_rect_stack: current clip rectangle plus a stack of saved rectangles.
// Push, reset and query beats go straight into the result register; a pop on a
// non-empty stack first passes through S_POP_LOAD for the synchronous stack read.
// Throughput: one beat per cycle while the result slot is free, except a pop on a
// non-empty stack, which holds the input while the block is in S_POP_LOAD.
// Reset (rst_n low, asynchronous): empty stack, full-screen clip, no result pending.
`default_nettype none

module clip_rect_stack
    import crs_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,

    input  wire                     cmd_valid,
    output logic                    cmd_stall,
    input  wire [1:0]               mode,
    input  wire signed [IN_W-1:0]   rect_x,
    input  wire signed [IN_W-1:0]   rect_y,
    input  wire signed [IN_W-1:0]   rect_w,
    input  wire signed [IN_W-1:0]   rect_h,

    output logic                    res_valid,
    input  wire                     res_stall,
    output logic [POS_W-1:0]        clip_x,
    output logic [POS_W-1:0]        clip_y,
    output logic [SIZE_W-1:0]       clip_w,
    output logic [SIZE_W-1:0]       clip_h,
    output logic [DEPTH_W-1:0]      stack_depth,
    output logic [1:0]              status
);

    // IDLE takes command beats; POP_LOAD waits for the stack read data.
    typedef enum logic {
        S_IDLE,
        S_POP_LOAD
    } state_t;

    state_t               state_reg, state_next;
    rect_t                cur_reg, cur_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic                 res_valid_reg, res_valid_next;
    rect_t                res_rect_reg, res_rect_next;
    logic [DEPTH_W-1:0]   res_depth_reg, res_depth_next;
    status_t              res_status_reg, res_status_next;

    // Saved rectangles: one write port, one registered read port.
    rect_t                stack_mem [STACK_DEPTH];
    rect_t                rd_data_reg;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [DEPTH_W-1:0]   depth_dec;

    logic                 accept;
    logic                 out_free;
    mode_t                cmd_mode;
    rect_t                isect_rect;

    crs_isect u_isect (
        .cur    (cur_reg),
        .rect_x (rect_x),
        .rect_y (rect_y),
        .rect_w (rect_w),
        .rect_h (rect_h),
        .nxt    (isect_rect)
    );

    // The result slot frees up when empty or when its beat is taken this cycle.
    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != S_IDLE) || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_mode  = mode_t'(mode);

    // Push writes the current rectangle at the depth index; pop reads one below it.
    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign wr_addr   = depth_reg[ADDR_W-1:0];
    assign rd_addr   = depth_dec[ADDR_W-1:0];
    assign wr_en     = accept && (cmd_mode == MODE_PUSH) && (depth_reg < DEPTH_FULL);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= cur_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        depth_next      = depth_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_rect_next   = res_rect_reg;
        res_depth_next  = res_depth_reg;
        res_status_next = res_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = STAT_OK;
                    unique case (cmd_mode)
                        MODE_PUSH:
                        begin
                            // narrow even when the save is dropped on a full stack
                            cur_next = isect_rect;
                            if (depth_reg < DEPTH_FULL)
                            begin
                                depth_next = depth_reg + DEPTH_W'(1);
                            end
                            else
                            begin
                                res_status_next = STAT_FULL;
                            end
                        end
                        MODE_POP:
                        begin
                            if (depth_reg != '0)
                            begin
                                // hold the result until the stack read returns
                                depth_next     = depth_dec;
                                res_valid_next = 1'b0;
                                state_next     = S_POP_LOAD;
                            end
                            else
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                        end
                        MODE_RESET:
                        begin
                            cur_next   = RESET_RECT;
                            depth_next = '0;
                        end
                        MODE_QUERY:
                        begin
                        end
                    endcase
                    res_rect_next  = cur_next;
                    res_depth_next = depth_next;
                end
            end
            S_POP_LOAD:
            begin
                // restore the top entry; the result slot was freed when the pop was taken
                cur_next        = rd_data_reg;
                res_valid_next  = 1'b1;
                res_rect_next   = rd_data_reg;
                res_depth_next  = depth_reg;
                res_status_next = STAT_OK;
                state_next      = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= RESET_RECT;
            depth_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_rect_reg   <= RESET_RECT;
            res_depth_reg  <= '0;
            res_status_reg <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            depth_reg      <= depth_next;
            res_valid_reg  <= res_valid_next;
            res_rect_reg   <= res_rect_next;
            res_depth_reg  <= res_depth_next;
            res_status_reg <= res_status_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign clip_x      = res_rect_reg.x;
    assign clip_y      = res_rect_reg.y;
    assign clip_w      = res_rect_reg.w;
    assign clip_h      = res_rect_reg.h;
    assign stack_depth = res_depth_reg;
    assign status      = res_status_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_clip_rect_stack.sv */
`timescale 1ns / 1ps
// tb_clip_rect_stack: self-checking testbench for the clip rectangle stack.
// Depends on crs_pkg (types, screen size, stack depth) and clip_rect_stack.

module tb_clip_rect_stack;
    import crs_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RUN_LIMIT_CYCLES = 400_000;
    localparam int DRAIN_LIMIT      = 5_000;
    localparam int TAIL_CYCLES      = 8;        // margin after the drain for the pop path's stack read
    localparam int RANDOM_TARGET    = 1_550;    // items sent before the calm tail starts
    localparam int TAIL_ITEMS       = 150;
    localparam int HOLD_OFF_CYCLES  = 120;

    // One expected result beat: the clip after the command, depth and status.
    typedef struct {
        rect_t             clip;
        logic [DEPTH_W-1:0] depth;
        status_t           stat;
    } clip_result_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    cmd_valid;
    logic                    cmd_stall;
    logic [1:0]              mode;
    logic signed [IN_W-1:0]  rect_x;
    logic signed [IN_W-1:0]  rect_y;
    logic signed [IN_W-1:0]  rect_w;
    logic signed [IN_W-1:0]  rect_h;
    logic                    res_valid;
    logic                    res_stall;
    logic [POS_W-1:0]        clip_x;
    logic [POS_W-1:0]        clip_y;
    logic [SIZE_W-1:0]       clip_w;
    logic [SIZE_W-1:0]       clip_h;
    logic [DEPTH_W-1:0]      stack_depth;
    logic [1:0]              status;

    clip_rect_stack u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .mode        (mode),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .clip_x      (clip_x),
        .clip_y      (clip_y),
        .clip_w      (clip_w),
        .clip_h      (clip_h),
        .stack_depth (stack_depth),
        .status      (status)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    clip_result_t expected_clips[$];   // oldest first, one per accepted command

    // Shadow of the block: current clip and the saved-rectangle stack.
    rect_t cur_clip;
    rect_t saved_clips[STACK_DEPTH];
    int    saved_count;

    int idle_pct    = 0;   // chance (percent) that either side starts an idle burst
    int hold_cycles = 0;   // long receiver hold-off, counted down by the receiver
    int fail_count  = 0;
    int items_sent  = 0;
    int results_seen = 0;
    int push_count, pop_count, full_pushes, empty_pops, deepest;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one accepted command to the shadow state and
    // return the beat the block must produce for it.
    // ------------------------------------------------------------------
    function automatic clip_result_t apply_cmd(mode_t m, logic signed [IN_W-1:0] x,
                                               logic signed [IN_W-1:0] y,
                                               logic signed [IN_W-1:0] w,
                                               logic signed [IN_W-1:0] h);
        clip_result_t res;
        int nx, ny, far_x, far_y, lim_x, lim_y;
        res.stat = STAT_OK;
        case (m)
            MODE_PUSH:
            begin
                push_count++;
                // Save first, so the pushed copy is the clip before narrowing.
                if (saved_count < STACK_DEPTH)
                begin
                    saved_clips[saved_count] = cur_clip;
                    saved_count++;
                end
                else
                begin
                    res.stat = STAT_FULL;
                    full_pushes++;
                end
                // Intersect: origin to the larger corner, far edge to the smaller.
                lim_x = int'(cur_clip.x) + int'(cur_clip.w);
                lim_y = int'(cur_clip.y) + int'(cur_clip.h);
                nx    = (int'(x) > int'(cur_clip.x)) ? int'(x) : int'(cur_clip.x);
                ny    = (int'(y) > int'(cur_clip.y)) ? int'(y) : int'(cur_clip.y);
                far_x = int'(x) + int'(w);
                far_y = int'(y) + int'(h);
                if (far_x > lim_x)
                    far_x = lim_x;
                if (far_y > lim_y)
                    far_y = lim_y;
                cur_clip.x = POS_W'(nx);
                cur_clip.y = POS_W'(ny);
                cur_clip.w = (far_x > nx) ? SIZE_W'(far_x - nx) : '0;
                cur_clip.h = (far_y > ny) ? SIZE_W'(far_y - ny) : '0;
            end
            MODE_POP:
            begin
                pop_count++;
                if (saved_count > 0)
                begin
                    saved_count--;
                    cur_clip = saved_clips[saved_count];
                end
                else
                begin
                    res.stat = STAT_EMPTY;
                    empty_pops++;
                end
            end
            MODE_RESET:
            begin
                saved_count = 0;
                cur_clip    = RESET_RECT;
            end
            default:
            begin
                // query: nothing moves
            end
        endcase
        if (saved_count > deepest)
            deepest = saved_count;
        res.clip  = cur_clip;
        res.depth = DEPTH_W'(saved_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional idle burst, then offer one command beat and hold it
    // until the block takes it. Valid stays high after acceptance so that
    // back-to-back beats need no extra edge.
    // ------------------------------------------------------------------
    task automatic send_cmd(mode_t m, logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                            logic signed [IN_W-1:0] w, logic signed [IN_W-1:0] h);
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        mode      <= m;
        rect_x    <= x;
        rect_y    <= y;
        rect_w    <= w;
        rect_h    <= h;
        // Accept on the first rising edge with stall low.
        do
            @(posedge clk);
        while (cmd_stall);
        expected_clips.push_back(apply_cmd(m, x, y, w, h));
        items_sent++;
    endtask

    // Push a rectangle close to the current clip so that nesting stays
    // non-trivial; sizes run a little past the clip and sometimes negative.
    task automatic push_near();
        int bx, by, bw, bh;
        bx = int'(cur_clip.x) - 8 + int'($urandom_range(0, 40));
        by = int'(cur_clip.y) - 8 + int'($urandom_range(0, 40));
        bw = int'($urandom_range(0, int'(cur_clip.w) + 24)) - 4;
        bh = int'($urandom_range(0, int'(cur_clip.h) + 24)) - 4;
        send_cmd(MODE_PUSH, IN_W'(bx), IN_W'(by), IN_W'(bw), IN_W'(bh));
    endtask

    // Any mode, every field bit random.
    task automatic send_noise();
        send_cmd(mode_t'($urandom_range(0, 3)), IN_W'($urandom), IN_W'($urandom),
                 IN_W'($urandom), IN_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result beat against the
    // oldest prediction, field by field.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    initial
    begin
        clip_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                if (expected_clips.size() == 0)
                begin
                    $error("result beat with nothing pending: x=%0d y=%0d w=%0d h=%0d",
                           clip_x, clip_y, clip_w, clip_h);
                    fail_count++;
                end
                else
                begin
                    want = expected_clips.pop_front();
                    check_field("clip_x", want.clip.x, clip_x);
                    check_field("clip_y", want.clip.y, clip_y);
                    check_field("clip_w", want.clip.w, clip_w);
                    check_field("clip_h", want.clip.h, clip_h);
                    check_field("stack_depth", want.depth, stack_depth);
                    check_field("status", want.stat, status);
                    results_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        int burst;
        burst     = 0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                res_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                res_stall <= 1'b1;
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                burst = $urandom_range(1, 19) - 1;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset: full screen, empty stack; pop on empty; explicit reset.
    task automatic test_reset_state();
        send_cmd(MODE_QUERY, 16'sh7fff, -16'sd1, 16'sh5555, -16'sd32768);
        send_cmd(MODE_POP, '0, '0, '0, '0);
        send_cmd(MODE_RESET, 16'shaaaa, 16'sh5555, '0, -16'sd1);
    endtask

    // Field extremes, empty and negative sizes, origin at the top of range,
    // exact full-screen push, reset with a loaded stack.
    task automatic test_push_pop_extremes();
        send_cmd(MODE_PUSH, 16'sd10, 16'sd20, 16'sd100, 16'sd50);
        send_cmd(MODE_PUSH, -16'sd5, -16'sd5, -16'sd1, -16'sd32768);
        send_cmd(MODE_POP, '0, '0, '0, '0);
        send_cmd(MODE_PUSH, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_cmd(MODE_PUSH, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_cmd(MODE_POP, '0, '0, '0, '0);
        send_cmd(MODE_POP, '0, '0, '0, '0);
        send_cmd(MODE_POP, '0, '0, '0, '0);
        send_cmd(MODE_PUSH, '0, '0, 16'(SCREEN_WIDTH), 16'(SCREEN_HEIGHT));
        send_cmd(MODE_PUSH, 16'sd100, 16'sd50, 16'sd1000, 16'sd1000);
        send_cmd(MODE_PUSH, 16'(SCREEN_WIDTH - 1), 16'(SCREEN_HEIGHT - 1), 16'sd1, 16'sd1);
        send_cmd(MODE_QUERY, '0, '0, '0, '0);
        send_cmd(MODE_RESET, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_cmd(MODE_POP, '0, '0, '0, '0);
        send_cmd(MODE_PUSH, -16'sd32768, -16'sd32768, -16'sd1, -16'sd1);
        send_cmd(MODE_RESET, '0, '0, '0, '0);
    endtask

    // Fill the stack, push past full (narrows without saving), then unwind
    // one past empty.
    task automatic test_stack_full();
        for (int i = 0; i < STACK_DEPTH + 2; i++)
            push_near();
        for (int i = 0; i < STACK_DEPTH + 1; i++)
            send_cmd(MODE_POP, IN_W'($urandom), IN_W'($urandom), '0, '0);
    endtask

    // Hold the result side off for a long stretch while commands keep
    // coming, so the block fills and stalls its input.
    task automatic test_output_backpressure();
        idle_pct    = 0;
        hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 4 == 3)
                send_cmd(MODE_POP, '0, '0, '0, '0);
            else
                push_near();
        end
    endtask

    // Episodes of well-formed nesting with random content, deep dives to
    // the full stack, bursts of noise and the odd reset.
    task automatic run_episodes(int stop_at, bit calm);
        int kind, n, unwind;
        while (items_sent < stop_at)
        begin
            if (calm)
                idle_pct = 0;
            else
                idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_cmd(MODE_PUSH, IN_W'($urandom), IN_W'($urandom),
                                 IN_W'($urandom), IN_W'($urandom));
                    else
                        push_near();
                    if ($urandom_range(0, 4) == 0)
                        send_cmd(MODE_QUERY, IN_W'($urandom), '0, '0, IN_W'($urandom));
                end
                // Now and then unwind one level too far.
                unwind = n + (($urandom_range(0, 5) == 0) ? 1 : 0);
                for (int i = 0; i < unwind; i++)
                    send_cmd(MODE_POP, IN_W'($urandom), IN_W'($urandom), '0, '0);
            end
            else if (kind < 65)
            begin
                while (saved_count < STACK_DEPTH)
                    push_near();
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_near();
                unwind = saved_count + 1;
                for (int i = 0; i < unwind; i++)
                    send_cmd(MODE_POP, '0, '0, '0, '0);
            end
            else if (kind < 90)
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    send_noise();
            end
            else
            begin
                send_cmd(MODE_RESET, IN_W'($urandom), IN_W'($urandom),
                         IN_W'($urandom), IN_W'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_episodes(RANDOM_TARGET, 1'b0);
    endtask

    // Last stretch with no idling on either side.
    task automatic test_quiet_tail();
        run_episodes(items_sent + TAIL_ITEMS, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("run limit hit with %0d results outstanding", expected_clips.size());
        $display("** clip_rect_stack: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        mode      = MODE_QUERY;
        rect_x    = '0;
        rect_y    = '0;
        rect_w    = '0;
        rect_h    = '0;
        cur_clip    = RESET_RECT;
        saved_count = 0;
        push_count  = 0;
        pop_count   = 0;
        full_pushes = 0;
        empty_pops  = 0;
        deepest     = 0;

        // Hold reset, then release it away from the rising edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_pct = 25;
        test_reset_state();
        test_push_pop_extremes();
        test_stack_full();
        test_output_backpressure();
        test_random_traffic();
        test_quiet_tail();

        // Drop valid, then drain everything still in flight.
        @(negedge clk);
        cmd_valid <= 1'b0;
        idle_pct  = 0;
        waited    = 0;
        while (expected_clips.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_clips.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_clips.size());
            fail_count++;
        end

        $display("covered %0d commands, %0d results: %0d pushes (%0d on a full stack),",
                 items_sent, results_seen, push_count, full_pushes);
        $display("  %0d pops (%0d on an empty stack), deepest nesting %0d, %0d mismatches",
                 pop_count, empty_pops, deepest, fail_count);
        if (fail_count == 0)
            $display("** clip_rect_stack: PASSED **");
        else
            $display("** clip_rect_stack: FAILED **");
        $finish;
    end

endmodule
